### src/mpbm_pkg.sv
// ----------------------------------------------------------------------------
// mpbm_pkg
// Shared types and constants of the multi-pattern byte matcher: request and
// response payloads, table entry layouts, and controller/datapath signals.
// ----------------------------------------------------------------------------
package mpbm_pkg;

   // automaton geometry
   localparam int STATE_W      = 10;
   localparam int NUM_STATES   = 1024;
   localparam int BYTE_W       = 8;
   localparam int ALPHABET     = 256;
   localparam int PAT_W        = 8;
   localparam int DEPTH_W      = 10;
   localparam int OFFSET_WIDTH = 32;
   localparam int START_W      = 32;
   localparam int GOTO_DEPTH   = NUM_STATES * ALPHABET;
   localparam int GOTO_AW      = $clog2(GOTO_DEPTH);
   localparam int STEP_W       = STATE_W + 1;

   // request operation codes
   localparam logic [1:0] OP_SCAN    = 2'd0;
   localparam logic [1:0] OP_GOTO_WR = 2'd1;
   localparam logic [1:0] OP_NODE_WR = 2'd2;

   typedef struct packed {
      logic [1:0]         operation;
      logic [BYTE_W-1:0]  byte_value;
      logic               end_of_buffer;
      logic [STATE_W-1:0] node_index;
      logic [STATE_W-1:0] child_state;
      logic               child_valid;
      logic [STATE_W-1:0] fail_state;
      logic               has_output;
      logic [PAT_W-1:0]   pattern_number;
      logic [DEPTH_W-1:0] node_depth;
   } req_type;

   typedef struct packed {
      logic               match_found;
      logic [PAT_W-1:0]   matched_pattern;
      logic [START_W-1:0] match_start;
      logic [DEPTH_W-1:0] match_length;
   } rsp_type;

   // goto table entry
   typedef struct packed {
      logic               valid;
      logic [STATE_W-1:0] child;
   } goto_entry_type;

   // node table entry
   typedef struct packed {
      logic [STATE_W-1:0] fail;
      logic               has_output;
      logic [PAT_W-1:0]   pattern;
      logic [DEPTH_W-1:0] depth;
   } node_entry_type;

   // controller to datapath
   typedef struct packed {
      logic clear_step;   // clear one goto entry
      logic load;         // capture the request
      logic write_item;   // table write or no-op, zero response
      logic follow_edge;  // take the goto edge, fetch child node entry
      logic follow_fail;  // move to the fail state
      logic end_scan;     // finish the byte and respond
      logic report;       // response may carry a match
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_last;
      logic goto_hit;
      logic at_root;
   } status_type;

endpackage

### src/mpbm_ram.sv
// ----------------------------------------------------------------------------
// mpbm_ram
// Generic single-port RAM, one write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
module mpbm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     write_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         write_data,
   output logic [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   // storage and registered read
   always_ff @(posedge clock) begin
      if (write_en) begin
         mem_ff[addr] <= write_data;
      end
      read_data_ff <= mem_ff[addr];
   end

   assign read_data = read_data_ff;

endmodule

### src/mpbm_datapath.sv
// ----------------------------------------------------------------------------
// mpbm_datapath
// Goto and node tables, current state, byte offset, fail-step count and the
// response register of the matcher.
// ----------------------------------------------------------------------------
module mpbm_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  mpbm_pkg::req_type    req_data,
   input  mpbm_pkg::cmd_type    cmd,
   output mpbm_pkg::status_type status,
   output logic                 rsp_strobe,
   output mpbm_pkg::rsp_type    rsp_data
);
   import mpbm_pkg::*;

   localparam logic [STEP_W-1:0] STEP_LIMIT = STEP_W'(NUM_STATES - 1);

   req_type            req_ff, req_in;
   logic [STATE_W-1:0] node_ff, node_in;
   logic [OFFSET_WIDTH-1:0] offset_ff, offset_in;
   logic [STEP_W-1:0]  steps_ff, steps_in;
   logic [GOTO_AW-1:0] clear_addr_ff, clear_addr_in;
   rsp_type            rsp_ff, rsp_in;
   logic               rsp_strobe_ff, rsp_strobe_in;

   logic               goto_we;
   logic [GOTO_AW-1:0] goto_addr;
   goto_entry_type     goto_wdata, goto_rd;
   logic               node_we;
   logic [STATE_W-1:0] node_addr;
   node_entry_type     node_wdata, node_rd;
   logic [OFFSET_WIDTH-1:0] start_full;

   // goto table port: clearing pass, software write, or lookup
   always_comb begin
      goto_we    = cmd.clear_step | (cmd.write_item & (req_ff.operation == OP_GOTO_WR));
      goto_wdata = '{valid: req_ff.child_valid, child: req_ff.child_state};
      if (cmd.clear_step) begin
         goto_addr  = clear_addr_ff;
         goto_wdata = '0;
      end else if (cmd.write_item) begin
         goto_addr = {req_ff.node_index, req_ff.byte_value};
      end else begin
         goto_addr = {node_ff, req_ff.byte_value};
      end
   end

   // node table port: write, child fetch, or current node fetch
   always_comb begin
      node_we    = cmd.write_item & (req_ff.operation == OP_NODE_WR);
      node_wdata = '{fail: req_ff.fail_state, has_output: req_ff.has_output,
                     pattern: req_ff.pattern_number, depth: req_ff.node_depth};
      if (cmd.write_item) begin
         node_addr = req_ff.node_index;
      end else if (cmd.follow_edge) begin
         node_addr = goto_rd.child;
      end else begin
         node_addr = node_ff;
      end
   end

   mpbm_ram #(
      .WIDTH ($bits(goto_entry_type)),
      .DEPTH (GOTO_DEPTH)
   ) u_goto_ram (
      .clock      (clock),
      .write_en   (goto_we),
      .addr       (goto_addr),
      .write_data (goto_wdata),
      .read_data  (goto_rd)
   );

   mpbm_ram #(
      .WIDTH ($bits(node_entry_type)),
      .DEPTH (NUM_STATES)
   ) u_node_ram (
      .clock      (clock),
      .write_en   (node_we),
      .addr       (node_addr),
      .write_data (node_wdata),
      .read_data  (node_rd)
   );

   assign status.clear_last = &clear_addr_ff;
   assign status.goto_hit   = goto_rd.valid;
   assign status.at_root    = (node_ff == '0);

   assign start_full = offset_ff + OFFSET_WIDTH'(1) - OFFSET_WIDTH'(node_rd.depth);

   // next state of the walk and response
   always_comb begin
      req_in        = req_ff;
      node_in       = node_ff;
      offset_in     = offset_ff;
      steps_in      = steps_ff;
      clear_addr_in = clear_addr_ff;
      rsp_in        = rsp_ff;
      rsp_strobe_in = 1'b0;

      if (cmd.clear_step) begin
         clear_addr_in = clear_addr_ff + GOTO_AW'(1);
      end
      if (cmd.load) begin
         req_in   = req_data;
         steps_in = '0;
      end
      if (cmd.write_item) begin
         rsp_in        = '0;
         rsp_strobe_in = 1'b1;
      end
      if (cmd.follow_edge) begin
         node_in = goto_rd.child;
      end
      // fail-link cycle guard: past the limit the walk restarts at the root
      if (cmd.follow_fail) begin
         node_in  = (steps_ff >= STEP_LIMIT) ? '0 : node_rd.fail;
         steps_in = steps_ff + STEP_W'(1);
      end
      if (cmd.end_scan) begin
         rsp_strobe_in = 1'b1;
         rsp_in        = '0;
         if (cmd.report && node_rd.has_output) begin
            rsp_in.match_found     = 1'b1;
            rsp_in.matched_pattern = node_rd.pattern;
            rsp_in.match_start     = START_W'(start_full);
            rsp_in.match_length    = node_rd.depth;
         end
         if (req_ff.end_of_buffer) begin
            node_in   = '0;
            offset_in = '0;
         end else begin
            offset_in = offset_ff + OFFSET_WIDTH'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_ff       <= '0;
         offset_ff     <= '0;
         steps_ff      <= '0;
         clear_addr_ff <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         node_ff       <= node_in;
         offset_ff     <= offset_in;
         steps_ff      <= steps_in;
         clear_addr_ff <= clear_addr_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

### src/mpbm_ctrl.sv
// ----------------------------------------------------------------------------
// mpbm_ctrl
// Sequencer of the matcher: goto table clearing after reset, table writes,
// and the goto / fail-link walk for each scanned byte.
// ----------------------------------------------------------------------------
module mpbm_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [1:0]           req_op,
   input  mpbm_pkg::status_type status,
   output mpbm_pkg::cmd_type    cmd,
   output logic                 busy
);
   import mpbm_pkg::*;

   typedef enum logic [5:0] {
      ST_CLEAR    = 6'b000001,
      ST_IDLE     = 6'b000010,
      ST_WRITE    = 6'b000100,
      ST_LOOKUP   = 6'b001000,
      ST_GOTO_CHK = 6'b010000,
      ST_OUT_CHK  = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = (req_op == OP_SCAN) ? ST_LOOKUP : ST_WRITE;
            end
         end
         ST_WRITE: begin
            cmd.write_item = 1'b1;
            state_in       = ST_IDLE;
         end
         // goto and node entries of the current state are being read
         ST_LOOKUP: begin
            state_in = ST_GOTO_CHK;
         end
         ST_GOTO_CHK: begin
            if (status.goto_hit) begin
               cmd.follow_edge = 1'b1;
               state_in        = ST_OUT_CHK;
            end else if (status.at_root) begin
               cmd.end_scan = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               cmd.follow_fail = 1'b1;
               state_in        = ST_LOOKUP;
            end
         end
         ST_OUT_CHK: begin
            cmd.end_scan = 1'b1;
            cmd.report   = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

### src/multi_pattern_byte_matcher.sv
// ----------------------------------------------------------------------------
// multi_pattern_byte_matcher
// Aho-Corasick matcher over a byte stream with software-loaded goto and node
// tables; reports pattern id, start offset and length on each match.
// ----------------------------------------------------------------------------
//
//   channel   ports                    handshake
//   -------   ----------------------   ------------------------------
//   request   start, busy, req_data    taken when start & !busy
//   response  rsp_strobe, rsp_data     one cycle, cannot be held off
//
// A scanned byte passes ST_LOOKUP and ST_GOTO_CHK, then ST_OUT_CHK when a goto
// edge is taken; a byte skipped at the root goes back to idle from ST_GOTO_CHK,
// and each fail link followed goes back through ST_LOOKUP; each step is one read of the goto and node RAMs.
// Table writes and no-op requests pass through ST_WRITE.
// Each request gives one response, strobed in the cycle busy drops.
// After reset the goto table is cleared one entry per cycle: busy stays high
// until the last entry is cleared.
//
module multi_pattern_byte_matcher (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  mpbm_pkg::req_type req_data,
   output logic              rsp_strobe,
   output mpbm_pkg::rsp_type rsp_data
);
   import mpbm_pkg::*;

   cmd_type    cmd;
   status_type status;

   mpbm_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .req_op (req_data.operation),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   mpbm_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .cmd        (cmd),
      .status     (status),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

### tb/sv/multi_pattern_byte_matcher_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_pattern_byte_matcher_checker
// Watches the request and response channels of the matcher. Every accepted
// request is run through a local copy of the automaton (goto table, node
// table, scan state), and the predicted response is queued. Every strobed
// response is compared with the oldest queued prediction.
// ----------------------------------------------------------------------------
module multi_pattern_byte_matcher_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  mpbm_pkg::req_type req_data,
   input  logic              rsp_strobe,
   input  mpbm_pkg::rsp_type rsp_data,
   output int                fail_count,
   output int                pending
);
   import mpbm_pkg::*;

   localparam int REPORT_LIMIT = 10;

   // local copy of the automaton and the scan position
   goto_entry_type          goto_table [GOTO_DEPTH];
   node_entry_type          node_table [NUM_STATES];
   logic [STATE_W-1:0]      scan_node;
   logic [OFFSET_WIDTH-1:0] scan_offset;

   rsp_type expected_matches [$];
   int      mismatch_count = 0;

   // goto table starts out all invalid, node table all zero
   initial begin
      for (int i = 0; i < GOTO_DEPTH; i++) begin
         goto_table[i] = '0;
      end
      for (int i = 0; i < NUM_STATES; i++) begin
         node_table[i] = '0;
      end
   end

   // apply one request to the local automaton and return its response
   function automatic rsp_type predict_match(input req_type r);
      rsp_type            res;
      logic [STATE_W-1:0] node;
      goto_entry_type     hop;
      int                 steps;
      logic               took_edge;
      logic               done;
      res = '0;
      case (r.operation)
         OP_GOTO_WR: begin
            goto_table[{r.node_index, r.byte_value}].valid = r.child_valid;
            goto_table[{r.node_index, r.byte_value}].child = r.child_state;
         end
         OP_NODE_WR: begin
            node_table[r.node_index].fail       = r.fail_state;
            node_table[r.node_index].has_output = r.has_output;
            node_table[r.node_index].pattern    = r.pattern_number;
            node_table[r.node_index].depth      = r.node_depth;
         end
         OP_SCAN: begin
            node      = scan_node;
            steps     = 0;
            took_edge = 1'b0;
            done      = 1'b0;
            // walk fail links until a child exists or the root gives up;
            // a walk that never ends is cut short at the root
            while (!done) begin
               if (steps >= NUM_STATES) node = '0;
               hop = goto_table[{node, r.byte_value}];
               if (hop.valid) begin
                  node      = hop.child;
                  took_edge = 1'b1;
                  done      = 1'b1;
               end else if (node == '0) begin
                  done = 1'b1;
               end else begin
                  node  = node_table[node].fail;
                  steps = steps + 1;
               end
            end
            if (took_edge && node_table[node].has_output) begin
               res.match_found     = 1'b1;
               res.matched_pattern = node_table[node].pattern;
               res.match_start     = scan_offset + 32'd1 - START_W'(node_table[node].depth);
               res.match_length    = node_table[node].depth;
            end
            // end of buffer returns the scan to the root at offset zero
            if (r.end_of_buffer) begin
               scan_node   = '0;
               scan_offset = '0;
            end else begin
               scan_node   = node;
               scan_offset = scan_offset + 32'd1;
            end
         end
         default: begin
         end
      endcase
      return res;
   endfunction

   // compare responses first, then queue the prediction for a new request
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         expected_matches.delete();
         scan_node      = '0;
         scan_offset    = '0;
         mismatch_count = 0;
      end else begin
         if (rsp_strobe) begin
            if (expected_matches.size() == 0) begin
               mismatch_count = mismatch_count + 1;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $display("response with no request pending: found=%0d id=%0d start=%0d len=%0d",
                           rsp_data.match_found, rsp_data.matched_pattern,
                           rsp_data.match_start, rsp_data.match_length);
               end
            end else begin
               want = expected_matches.pop_front();
               if (rsp_data.match_found !== want.match_found ||
                   rsp_data.matched_pattern !== want.matched_pattern ||
                   rsp_data.match_start !== want.match_start ||
                   rsp_data.match_length !== want.match_length) begin
                  mismatch_count = mismatch_count + 1;
                  if (mismatch_count <= REPORT_LIMIT) begin
                     $display("mismatch: expected found=%0d id=%0d start=%0d len=%0d",
                              want.match_found, want.matched_pattern,
                              want.match_start, want.match_length);
                     $display("          actual   found=%0d id=%0d start=%0d len=%0d",
                              rsp_data.match_found, rsp_data.matched_pattern,
                              rsp_data.match_start, rsp_data.match_length);
                  end
               end
            end
         end
         if (start && !busy) begin
            expected_matches.push_back(predict_match(req_data));
         end
      end
      fail_count <= mismatch_count;
      pending    <= expected_matches.size();
   end

endmodule

### tb/sv/multi_pattern_byte_matcher_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_pattern_byte_matcher_test
// Drives the matcher with a directed opening (field extremes, match and skip,
// cleared edges, a fail-link loop, end of buffer, no-op requests) and then with
// random automata loaded phase by phase and scanned with bytes drawn mostly
// from each phase's small alphabet, mixed with stray writes and noise bytes.
// The checker beside the block predicts and compares; this module gives the
// verdict.
// ----------------------------------------------------------------------------
module multi_pattern_byte_matcher_test;
   import mpbm_pkg::*;

   localparam logic [1:0] OP_NONE = 2'd3;

   localparam int ITEM_TARGET  = 1050;
   localparam int MAX_GAP      = 60;
   localparam int DRAIN_CYCLES = 32;
   localparam int SLOWEST_ITEM = 4 + 2 * (NUM_STATES + 1) + MAX_GAP;
   localparam int CYCLE_LIMIT  = 4 * (GOTO_DEPTH + (ITEM_TARGET + 250) * SLOWEST_ITEM);

   logic    clock;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_strobe;
   rsp_type rsp_data;
   int      fail_count;
   int      pending;
   int      cycle_count = 0;

   // stimulus bookkeeping: node entries written so far
   bit node_written [NUM_STATES];
   int written_list [$];
   int item_count = 0;
   bit steady = 1'b0;

   multi_pattern_byte_matcher uut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   multi_pattern_byte_matcher_checker checker_inst (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL multi_pattern_byte_matcher");
         $finish;
      end
   end

   // request with every field random; callers overwrite what matters
   function automatic req_type random_request();
      logic [63:0] raw;
      raw = {$urandom, $urandom};
      return raw[$bits(req_type)-1:0];
   endfunction

   // a written node below n, so fail chains always descend; root otherwise
   function automatic logic [STATE_W-1:0] pick_fail(input int n);
      logic [STATE_W-1:0] choice;
      int                 cand;
      choice = '0;
      for (int k = 0; k < 6; k++) begin
         cand = written_list[$urandom_range(0, written_list.size() - 1)];
         if (cand < n && choice == '0) choice = STATE_W'(cand);
      end
      return choice;
   endfunction

   // idle for a random gap (none when steady), then hold the request until it is taken
   task automatic issue(input req_type r);
      int gap;
      int roll;
      gap = 0;
      if (!steady) begin
         roll = $urandom_range(0, 99);
         if (roll < 55) gap = 0;
         else if (roll < 85) gap = $urandom_range(1, 3);
         else if (roll < 97) gap = $urandom_range(4, 12);
         else gap = $urandom_range(20, MAX_GAP);
      end
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_data <= r;
      start    <= 1'b1;
      @(negedge clock);
      while (busy) @(negedge clock);
      @(posedge clock);
      if (r.operation != OP_NONE) item_count++;
   endtask

   task automatic write_node(input logic [STATE_W-1:0] idx, input logic [STATE_W-1:0] fail,
                             input logic has_out, input logic [PAT_W-1:0] pat,
                             input logic [DEPTH_W-1:0] depth);
      req_type r;
      r = random_request();
      r.operation      = OP_NODE_WR;
      r.node_index     = idx;
      r.fail_state     = fail;
      r.has_output     = has_out;
      r.pattern_number = pat;
      r.node_depth     = depth;
      issue(r);
      if (!node_written[idx]) begin
         node_written[idx] = 1'b1;
         written_list.push_back(int'(idx));
      end
   endtask

   task automatic write_goto(input logic [STATE_W-1:0] idx, input logic [BYTE_W-1:0] b,
                             input logic [STATE_W-1:0] child, input logic valid);
      req_type r;
      r = random_request();
      r.operation   = OP_GOTO_WR;
      r.node_index  = idx;
      r.byte_value  = b;
      r.child_state = child;
      r.child_valid = valid;
      issue(r);
   endtask

   task automatic scan_byte(input logic [BYTE_W-1:0] b, input logic last);
      req_type r;
      r = random_request();
      r.operation     = OP_SCAN;
      r.byte_value    = b;
      r.end_of_buffer = last;
      issue(r);
   endtask

   task automatic send_none();
      req_type r;
      r = random_request();
      r.operation = OP_NONE;
      issue(r);
   endtask

   initial begin
      logic [BYTE_W-1:0]  alpha [3];
      logic [STATE_W-1:0] fail_pick;
      logic [STATE_W-1:0] src;
      int                 ids [16];
      int                 depths [16];
      int                 node_total;
      int                 cur;
      int                 parent;
      int                 pdepth;
      int                 sel;
      int                 scan_total;
      int                 phase;
      int                 roll;
      int                 target;
      logic               valid;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // --- directed part ---
      // root, and a deepest node with the widest id and depth
      write_node(10'd0, 10'd0, 1'b0, 8'd0, 10'd0);
      write_node(10'd1023, 10'd0, 1'b1, 8'd255, 10'd1023);
      write_goto(10'd0, 8'hff, 10'd1023, 1'b1);
      scan_byte(8'hff, 1'b0);              // match, start wraps below zero
      scan_byte(8'h00, 1'b0);              // fail to root, byte skipped
      // pattern id zero still reports a match
      write_node(10'd1, 10'd0, 1'b1, 8'd0, 10'd1);
      write_goto(10'd0, 8'h00, 10'd1, 1'b1);
      scan_byte(8'h00, 1'b0);
      write_goto(10'd0, 8'h00, 10'd1, 1'b0); // edge cleared
      scan_byte(8'h00, 1'b0);
      // two nodes failing to each other: the walk is cut short at the root
      write_node(10'd6, 10'd5, 1'b0, 8'd0, 10'd2);
      write_node(10'd5, 10'd6, 1'b0, 8'd0, 10'd1);
      write_goto(10'd0, 8'h11, 10'd5, 1'b1);
      scan_byte(8'h11, 1'b0);
      scan_byte(8'h22, 1'b0);              // loop, then skip at the root
      scan_byte(8'h11, 1'b0);
      write_goto(10'd0, 8'h33, 10'd1, 1'b1);
      scan_byte(8'h33, 1'b0);              // loop, then the root edge matches
      // end of buffer resets state and offset
      scan_byte(8'h11, 1'b1);
      scan_byte(8'h33, 1'b0);
      send_none();
      // an edge back to the root itself
      write_goto(10'd0, 8'h44, 10'd0, 1'b1);
      scan_byte(8'h44, 1'b0);
      // break the loop so later fail chains always end
      write_node(10'd5, 10'd0, 1'b0, 8'd0, 10'd1);
      write_node(10'd6, 10'd5, 1'b0, 8'd0, 10'd2);

      // --- random part: one small automaton per phase, then a scan over it ---
      phase = 0;
      while (item_count < ITEM_TARGET) begin
         steady = ($urandom_range(0, 2) == 0);
         for (int k = 0; k < 3; k++) alpha[k] = BYTE_W'($urandom);
         if (phase == 0) begin
            alpha[0] = 8'h00;
            alpha[1] = 8'hff;
         end

         // trie in ascending state order: parents and fail targets come first
         node_total = $urandom_range(6, 14);
         cur = 0;
         for (int k = 0; k < node_total; k++) begin
            cur = cur + $urandom_range(1, (NUM_STATES - 1 - cur) / (node_total - k));
            ids[k] = cur;
            parent = $urandom_range(0, k);
            pdepth = (parent == 0) ? 0 : depths[parent - 1];
            depths[k] = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023) : pdepth + 1;
            sel = $urandom_range(0, 9);
            if (sel < 5 && k > 0) fail_pick = STATE_W'(ids[$urandom_range(0, k - 1)]);
            else if (sel < 8) fail_pick = pick_fail(cur);
            else fail_pick = '0;
            write_node(STATE_W'(cur), fail_pick, $urandom_range(0, 99) < 40,
                       PAT_W'($urandom), DEPTH_W'(depths[k]));
            src = (parent == 0) ? '0 : STATE_W'(ids[parent - 1]);
            write_goto(src, alpha[$urandom_range(0, 2)], STATE_W'(cur), 1'b1);
         end

         // scan mostly in-alphabet bytes, with stray writes and noise
         scan_total = $urandom_range(80, 140);
         for (int k = 0; k < scan_total; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < 82) begin
               scan_byte(alpha[$urandom_range(0, 2)], $urandom_range(0, 39) == 0);
            end else if (roll < 86) begin
               scan_byte(BYTE_W'($urandom), 1'b0);
            end else if (roll < 90) begin
               valid = 1'($urandom_range(0, 1));
               target = valid ? written_list[$urandom_range(0, written_list.size() - 1)]
                              : $urandom_range(0, NUM_STATES - 1);
               write_goto(STATE_W'($urandom), BYTE_W'($urandom), STATE_W'(target), valid);
            end else if (roll < 94) begin
               cur = $urandom_range(0, NUM_STATES - 1);
               fail_pick = (cur == 0) ? STATE_W'($urandom) : pick_fail(cur);
               write_node(STATE_W'(cur), fail_pick, 1'($urandom_range(0, 1)),
                          PAT_W'($urandom), DEPTH_W'($urandom));
            end else if (roll < 97) begin
               send_none();
            end else begin
               scan_byte(BYTE_W'($urandom), 1'b1);
            end
         end
         phase++;
      end

      // --- wind down and give the verdict ---
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("PASS multi_pattern_byte_matcher");
      end else begin
         $display("FAIL multi_pattern_byte_matcher");
      end
      $finish;
   end

endmodule
